// ===== design/ball_position_error_integrator_top_macros.svh =====
// Assertion macros for the top-level design file.
// ASSERT_IMPL checks that the consequent holds in the same cycle as the antecedent.
// ASSERT_NEXT checks that the consequent holds in the cycle after the antecedent.
// Both stay quiet while rst_n is low, and both turn into nothing when SYNTHESIS is defined.
`ifndef BALL_POSITION_ERROR_INTEGRATOR_TOP_MACROS_SVH
`define BALL_POSITION_ERROR_INTEGRATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/bpei_pkg.sv =====
package bpei_pkg;

  // Position width of the internal coordinate registers.
  localparam int POS_W     = 15;
  localparam int POS_MAX   = (1 << POS_W) - 1;
  localparam int POS_RESET = 40;

  // Digit accumulator holds up to 255*111, independent of POS_W.
  localparam int DACC_W = 15;
  localparam int SAT_W  = ((POS_W > DACC_W) ? POS_W : DACC_W) + 1;

  localparam int SP_W   = 10;
  localparam int WIN_W  = 6;
  localparam int BAND_W = 8;
  localparam int LIM_W  = 7;
  localparam int ACC_W  = 8;
  localparam int ERR_W  = POS_W + 2;
  localparam int INT_W  = ERR_W + 1;

  localparam int OUT_POS_W = 15;
  localparam int OUT_ERR_W = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [7:0] HDR_X      = 8'h41;
  localparam logic [7:0] HDR_Y      = 8'h42;
  localparam logic [7:0] DIGIT_BASE = 8'd48;

  localparam logic [SP_W-1:0]   X_SP_RESET   = SP_W'(40);
  localparam logic [SP_W-1:0]   Y_SP_RESET   = SP_W'(40);
  localparam logic [WIN_W-1:0]  WIN_RESET    = WIN_W'(5);
  localparam logic [BAND_W-1:0] BAND_RESET   = BAND_W'(20);
  localparam logic [LIM_W-1:0]  LIMIT_RESET  = LIM_W'(25);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_X_SETPOINT     = 3'd0,
    REG_Y_SETPOINT     = 3'd1,
    REG_SETTLE_WINDOW  = 3'd2,
    REG_ERROR_BAND     = 3'd3,
    REG_INTEGRAL_LIMIT = 3'd4
  } cfg_reg_t;

  // What the parser asks of the datapath for the word at its input.
  typedef struct packed {
    logic             update;
    logic             load_x;
    logic             load_y;
    logic [POS_W-1:0] value;
  } parse_cmd_t;

  typedef struct packed {
    logic             step;
    logic             load;
    logic             snap;
    logic [POS_W-1:0] value;
  } axis_ctl_t;

  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic signed [ERR_W-1:0] err;
    logic signed [ACC_W-1:0] acc;
    logic                    en;
  } axis_res_t;

  // Open window test: sp - w < pos < sp + w.
  function automatic logic in_window(input logic [POS_W-1:0] pos,
                                     input logic [SP_W-1:0] sp,
                                     input logic [WIN_W-1:0] w);
    logic signed [ERR_W-1:0] diff;
    logic signed [ERR_W-1:0] wext;
    diff = $signed(ERR_W'(pos)) - $signed(ERR_W'(sp));
    wext = $signed(ERR_W'(w));
    return (diff > -wext) && (diff < wext);
  endfunction

endpackage

// ===== design/bpei_parse.sv =====
module bpei_parse import bpei_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] rx_byte,
  input  logic       fire,
  output parse_cmd_t cmd
);

  typedef enum logic [3:0] {
    PH_HDR = 4'b0001,
    PH_D1  = 4'b0010,
    PH_D2  = 4'b0100,
    PH_D3  = 4'b1000
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic                axis_y_r, axis_y_nxt;
  logic [DACC_W-1:0]   dacc_r, dacc_nxt;
  logic [7:0]          digit;
  logic [SAT_W-1:0]    total;

  // Any byte counts as a digit, wrapping modulo 256.
  assign digit = rx_byte - DIGIT_BASE;
  assign total = SAT_W'(dacc_r) + SAT_W'(digit);

  always_comb begin
    phase_nxt  = phase_r;
    axis_y_nxt = axis_y_r;
    dacc_nxt   = dacc_r;
    cmd        = '0;
    unique case (phase_r)
      PH_HDR: begin
        if (rx_byte == HDR_X || rx_byte == HDR_Y) begin
          axis_y_nxt = (rx_byte == HDR_Y);
          dacc_nxt   = '0;
          phase_nxt  = PH_D1;
        end else begin
          cmd.update = 1'b1;
        end
      end
      PH_D1: begin
        dacc_nxt  = DACC_W'(digit) * DACC_W'(100);
        phase_nxt = PH_D2;
      end
      PH_D2: begin
        dacc_nxt  = dacc_r + DACC_W'(digit) * DACC_W'(10);
        phase_nxt = PH_D3;
      end
      PH_D3: begin
        cmd.update = 1'b1;
        cmd.load_x = !axis_y_r;
        cmd.load_y = axis_y_r;
        if (total > SAT_W'(POS_MAX)) begin
          cmd.value = POS_W'(POS_MAX);
        end else begin
          cmd.value = POS_W'(total);
        end
        phase_nxt = PH_HDR;
      end
      default: begin
        phase_nxt = PH_HDR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR;
      axis_y_r <= 1'b0;
      dacc_r   <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      axis_y_r <= axis_y_nxt;
      dacc_r   <= dacc_nxt;
    end
  end

endmodule

// ===== design/bpei_axis.sv =====
module bpei_axis import bpei_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  axis_ctl_t         ctl,
  input  logic [SP_W-1:0]   setpoint,
  input  logic [BAND_W-1:0] band,
  input  logic [LIM_W-1:0]  limit,
  output logic [POS_W-1:0]  pos_pre,
  output axis_res_t         res
);

  logic [POS_W-1:0]        cur_r, prev_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [POS_W-1:0]        sample;
  logic [POS_W:0]          pair_sum;
  logic [POS_W-1:0]        avg;
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W-1:0] band_s;
  logic                    out_band;
  logic signed [INT_W-1:0] integ, lim_s;

  // Position after a parsed coordinate lands, before the settle snap.
  assign pos_pre  = ctl.load ? ctl.value : cur_r;
  assign sample   = ctl.snap ? POS_W'(setpoint) : pos_pre;
  assign pair_sum = {1'b0, sample} + {1'b0, prev_r};
  assign avg      = pair_sum[POS_W:1];
  assign err      = $signed(ERR_W'(avg)) - $signed(ERR_W'(setpoint));
  assign band_s   = $signed(ERR_W'(band));
  assign out_band = (err > band_s) || (err < -band_s);
  assign lim_s    = $signed(INT_W'(limit));

  always_comb begin
    if (out_band) begin
      integ = '0;
    end else begin
      integ = {{(INT_W-ACC_W){acc_r[ACC_W-1]}}, acc_r} + {err[ERR_W-1], err};
    end
    if (integ > lim_s) begin
      integ = lim_s;
    end else if (integ < -lim_s) begin
      integ = -lim_s;
    end
    acc_nxt = integ[ACC_W-1:0];
  end

  assign res.pos = avg;
  assign res.err = err;
  assign res.acc = acc_nxt;
  assign res.en  = !out_band;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= POS_W'(POS_RESET);
      prev_r <= '0;
      acc_r  <= '0;
    end else if (ctl.step) begin
      cur_r  <= avg;
      prev_r <= sample;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// ===== design/ball_position_error_integrator_top.sv =====
// Channel | Direction | Word contents (lowest bit first)
// in_     | slave     | rx_byte[7:0]
// out_    | master    | x_position, y_position, x_error, y_error, x_integral,
//         |           | y_integral, x_integral_enable, y_integral_enable (80 bits)
// cfg_    | slave     | cfg_addr = register index, cfg_data = register value
//
// Input words stream back to back through the processing stage while the output has room.
// A word is taken into the input stage; its result is registered in the output register
// when the word proceeds, which can wait on room at the output.
// The cycle time is set by the combinational update chain: parse, settle test,
// averaging add, error subtract, integral add and clamp.
// Reset (rst_n low, synchronous) restores all but the input byte and output data.
// A stalled output holds its word; input continues until the processing stage fills.
`include "ball_position_error_integrator_top_macros.svh"

module ball_position_error_integrator_top import bpei_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [14:0] x_position, [29:15] y_position, [45:30] x_error, [61:46] y_error,
  // [69:62] x_integral, [77:70] y_integral, [78] x_integral_enable,
  // [79] y_integral_enable
  output logic [79:0]           out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [SP_W-1:0]   x_sp_r, y_sp_r;
  logic [WIN_W-1:0]  window_r;
  logic [BAND_W-1:0] band_r;
  logic [LIM_W-1:0]  limit_r;

  // Input stage holding the word under processing.
  logic       s1_vld_r, s1_vld_nxt;
  logic [7:0] s1_byte_r;

  // Output register.
  logic       out_vld_r, out_vld_nxt;
  axis_res_t  out_x_r, out_y_r;

  parse_cmd_t cmd;
  axis_ctl_t  x_ctl, y_ctl;
  axis_res_t  x_res, y_res;
  logic [POS_W-1:0] x_pre, y_pre;
  logic [1:0] settle_cnt_r;
  logic       settled, snap, out_room, fire, step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_sp_r   <= X_SP_RESET;
      y_sp_r   <= Y_SP_RESET;
      window_r <= WIN_RESET;
      band_r   <= BAND_RESET;
      limit_r  <= LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_X_SETPOINT:     x_sp_r   <= cfg_data[SP_W-1:0];
        REG_Y_SETPOINT:     y_sp_r   <= cfg_data[SP_W-1:0];
        REG_SETTLE_WINDOW:  window_r <= cfg_data[WIN_W-1:0];
        REG_ERROR_BAND:     band_r   <= cfg_data[BAND_W-1:0];
        REG_INTEGRAL_LIMIT: limit_r  <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // A word without a result always proceeds; one with a result needs room at the output.
  assign out_room  = !out_vld_r || out_tready;
  assign fire      = s1_vld_r && (!cmd.update || out_room);
  assign step      = fire && cmd.update;
  assign in_tready = !s1_vld_r || fire;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_tvalid && in_tready) begin
      s1_vld_nxt = 1'b1;
    end else if (fire) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
  end

  bpei_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .rx_byte (s1_byte_r),
    .fire    (fire),
    .cmd     (cmd)
  );

  // Both axes must sit inside the window; after three such updates they snap.
  assign settled = in_window(x_pre, x_sp_r, window_r) && in_window(y_pre, y_sp_r, window_r);
  assign snap    = settled && (settle_cnt_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_cnt_r <= '0;
    end else if (step) begin
      if (!settled) begin
        settle_cnt_r <= '0;
      end else if (!snap) begin
        settle_cnt_r <= settle_cnt_r + 2'd1;
      end
    end
  end

  assign x_ctl = '{step: step, load: cmd.load_x, snap: snap, value: cmd.value};
  assign y_ctl = '{step: step, load: cmd.load_y, snap: snap, value: cmd.value};

  bpei_axis u_axis_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (x_ctl),
    .setpoint (x_sp_r),
    .band     (band_r),
    .limit    (limit_r),
    .pos_pre  (x_pre),
    .res      (x_res)
  );

  bpei_axis u_axis_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (y_ctl),
    .setpoint (y_sp_r),
    .band     (band_r),
    .limit    (limit_r),
    .pos_pre  (y_pre),
    .res      (y_res)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_room) begin
      out_vld_nxt = step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_x_r <= x_res;
      out_y_r <= y_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_y_r.en, out_x_r.en, out_y_r.acc, out_x_r.acc,
                       OUT_ERR_W'(out_y_r.err), OUT_ERR_W'(out_x_r.err),
                       OUT_POS_W'(out_y_r.pos), OUT_POS_W'(out_x_r.pos)};

  // The snap only happens once three settled updates have been counted.
  `ASSERT_IMPL(a_snap_after_count, snap, settle_cnt_r == 2'd3)
  // An update that proceeds always leaves a result in the output register.
  `ASSERT_NEXT(a_step_fills_out, step, out_vld_r)
  // A word that cannot proceed stays in the input stage unchanged.
  `ASSERT_NEXT(a_s1_holds, s1_vld_r && !fire, s1_vld_r && $stable(s1_byte_r))

endmodule

// ===== verif/ball_position_error_integrator_top_tb.sv =====
`timescale 1ns / 100ps

module ball_position_error_integrator_top_tb import bpei_pkg::*; ();

  // The run stops here even if the block hangs.
  localparam int CYCLE_LIMIT  = 400000;
  // Only the first few mismatches are printed in full; the rest are only counted.
  localparam int REPORT_LIMIT = 10;
  // Random words sent per configuration phase.
  localparam int RANDOM_WORDS = 150;
  // A result passes the input stage and the output register after its word is taken, so the
  // drain time is enough for a trailing header or digit to be absorbed.
  localparam int DRAIN_CYCLES = 8;
  // Largest coordinate that the 15 bit position registers can hold.
  localparam int POS_CEIL     = 32767;
  // Largest reading that three decimal digits can express.
  localparam int DECIMAL_MAX  = 999;
  localparam int PHASES       = 6;

  // One result word, declared from the top bit down so that a cast from the
  // 80 bit out_tdata lands every field in place.
  typedef struct packed {
    logic               y_en;
    logic               x_en;
    logic signed [7:0]  y_int;
    logic signed [7:0]  x_int;
    logic signed [15:0] y_err;
    logic signed [15:0] x_err;
    logic [14:0]        y_pos;
    logic [14:0]        x_pos;
  } sample_t;

  // Where the serial parser stands: waiting for a header, or for one of the
  // three digits that follow it.
  typedef enum int {
    AWAIT_HEADER,
    AWAIT_HUNDREDS,
    AWAIT_TENS,
    AWAIT_UNITS
  } parse_state_t;

  // The scoreboard keeps its own copy of the parser, the two axis filters and
  // the integrators. Every accepted input word is run through it, and any
  // update it causes leaves one expected sample in the queue.
  class bpei_scoreboard;
    int           setpoint [2];
    int           window;
    int           band;
    int           limit;
    parse_state_t state;
    bit           on_y;
    int           digit_sum;
    int           coord [2];
    int           last_sample [2];
    int           settle_run;
    int           integral [2];
    sample_t      expected_samples [$];
    int           mismatches;
    int           checked;

    function new();
      setpoint[0]    = 40;
      setpoint[1]    = 40;
      window         = 5;
      band           = 20;
      limit          = 25;
      state          = AWAIT_HEADER;
      on_y           = 0;
      digit_sum      = 0;
      coord[0]       = 40;
      coord[1]       = 40;
      last_sample[0] = 0;
      last_sample[1] = 0;
      settle_run     = 0;
      integral[0]    = 0;
      integral[1]    = 0;
      mismatches     = 0;
      checked        = 0;
    endfunction

    function void set_reg(cfg_reg_t r, int v);
      case (r)
        REG_X_SETPOINT:     setpoint[0] = v & 'h3ff;
        REG_Y_SETPOINT:     setpoint[1] = v & 'h3ff;
        REG_SETTLE_WINDOW:  window      = v & 'h3f;
        REG_ERROR_BAND:     band        = v & 'hff;
        REG_INTEGRAL_LIMIT: limit       = v & 'h7f;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    // The settle window is open on both sides, so a zero window never passes.
    function bit near_setpoint(int a);
      int diff;
      diff = coord[a] - setpoint[a];
      return diff > -window && diff < window;
    endfunction

    // Two-sample average rounded down, then the error and its clamped integral.
    function void advance_axis(int a, output int err, output bit en);
      int smoothed;
      int sum;
      smoothed       = (coord[a] + last_sample[a]) / 2;
      last_sample[a] = coord[a];
      coord[a]       = smoothed;
      err            = smoothed - setpoint[a];
      sum            = integral[a] + err;
      if (err > band || err < -band) begin
        sum = 0;
        en  = 0;
      end else begin
        en = 1;
      end
      if (sum > limit) sum = limit;
      if (sum < -limit) sum = -limit;
      integral[a] = sum;
    endfunction

    function void update_position();
      sample_t s;
      int      err [2];
      bit      en [2];
      // Four consecutive updates inside the window snap both axes onto the
      // setpoint; the run count then stays at three.
      if (near_setpoint(0) && near_setpoint(1)) begin
        if (settle_run == 3) begin
          coord[0] = setpoint[0];
          coord[1] = setpoint[1];
        end else begin
          settle_run++;
        end
      end else begin
        settle_run = 0;
      end
      advance_axis(0, err[0], en[0]);
      advance_axis(1, err[1], en[1]);
      s.x_pos = 15'(coord[0]);
      s.y_pos = 15'(coord[1]);
      s.x_err = 16'(err[0]);
      s.y_err = 16'(err[1]);
      s.x_int = 8'(integral[0]);
      s.y_int = 8'(integral[1]);
      s.x_en  = en[0];
      s.y_en  = en[1];
      expected_samples.push_back(s);
    endfunction

    // Any byte is taken as a digit once a header has been seen, headers too,
    // with the value (byte - '0') wrapped to eight bits.
    function void note_byte(logic [7:0] b);
      logic [7:0] digit;
      int         value;
      digit = b - DIGIT_BASE;
      case (state)
        AWAIT_HUNDREDS: begin
          digit_sum = int'(digit) * 100;
          state     = AWAIT_TENS;
        end
        AWAIT_TENS: begin
          digit_sum += int'(digit) * 10;
          state      = AWAIT_UNITS;
        end
        AWAIT_UNITS: begin
          value = digit_sum + int'(digit);
          if (value > POS_CEIL) value = POS_CEIL;
          coord[on_y] = value;
          state       = AWAIT_HEADER;
          update_position();
        end
        default: begin
          if (b == HDR_X || b == HDR_Y) begin
            on_y      = (b == HDR_Y);
            digit_sum = 0;
            state     = AWAIT_HUNDREDS;
          end else begin
            // Any other byte between frames updates the filters with the
            // coordinates unchanged.
            update_position();
          end
        end
      endcase
    endfunction

    function void check_result(logic [79:0] word);
      sample_t got;
      sample_t want;
      got = sample_t'(word);
      checked++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d arrived with nothing expected: %h", checked, word);
        return;
      end
      want = expected_samples.pop_front();
      if (got.x_pos !== want.x_pos || got.y_pos !== want.y_pos ||
          got.x_err !== want.x_err || got.y_err !== want.y_err ||
          got.x_int !== want.x_int || got.y_int !== want.y_int ||
          got.x_en !== want.x_en || got.y_en !== want.y_en) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result %0d expected pos %0d,%0d err %0d,%0d int %0d,%0d en %b,%b",
                   checked, want.x_pos, want.y_pos, want.x_err, want.y_err,
                   want.x_int, want.y_int, want.x_en, want.y_en);
          $display("result %0d actual   pos %0d,%0d err %0d,%0d int %0d,%0d en %b,%b",
                   checked, got.x_pos, got.y_pos, got.x_err, got.y_err,
                   got.x_int, got.y_int, got.x_en, got.y_en);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [79:0]           out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  bpei_scoreboard sb;
  // Chance in percent that the sender holds back, and that the
  // receiver stalls, at each draw. Both change from phase to phase.
  int             in_idle_pct;
  int             out_stall_pct;
  int             sent_words;
  int             cycles = 0;

  ball_position_error_integrator_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver decides at each falling edge whether it takes a word at the
  // next rising edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Result words are taken at the rising edge where valid and ready meet.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Watchdog: a block that stops answering ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offers one byte, after a random number of idle cycles, and returns at the
  // rising edge that takes it. in_tvalid stays high so that back-to-back words
  // need no second assignment in one time step.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b);
    sent_words++;
  endtask

  // A well formed frame: header, then the reading as three decimal digits.
  task automatic send_reading(input bit on_y, input int value);
    send_byte(on_y ? HDR_Y : HDR_X);
    send_byte(DIGIT_BASE + 8'(value / 100));
    send_byte(DIGIT_BASE + 8'((value / 10) % 10));
    send_byte(DIGIT_BASE + 8'(value % 10));
  endtask

  // Register writes are issued only while no word is in flight. cfg_valid is
  // left high between writes and lowered by load_settings.
  task automatic write_reg(input cfg_reg_t r, input int v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= r;
    cfg_data  <= CFG_DATA_W'(v);
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(r, v);
  endtask

  task automatic load_settings(input int xs, input int ys, input int win,
                               input int band, input int lim);
    write_reg(REG_X_SETPOINT, xs);
    write_reg(REG_Y_SETPOINT, ys);
    write_reg(REG_SETTLE_WINDOW, win);
    write_reg(REG_ERROR_BAND, band);
    write_reg(REG_INTEGRAL_LIMIT, lim);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Each phase picks a handshake pattern and a register setting. The first
  // three cover the reset values and both extremes, including the empty
  // settle window and the zero integral limit.
  task automatic apply_phase(input int p);
    case (p % 4)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 79; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 79; end
      default: begin in_idle_pct = 10; out_stall_pct = 10; end
    endcase
    case (p)
      0: load_settings(40, 40, 5, 20, 25);
      1: load_settings(0, 1023, 63, 255, 127);
      2: load_settings(1023, 0, 0, 0, 0);
      4: load_settings($urandom_range(600, 20), $urandom_range(600, 20),
                       $urandom_range(15, 3), $urandom_range(80, 10),
                       $urandom_range(127, 1));
      default: load_settings($urandom_range(1023), $urandom_range(1023),
                             $urandom_range(63), $urandom_range(255),
                             $urandom_range(127));
    endcase
  endtask

  // Short directed opening at the reset setting: stray bytes at both ends of
  // the range, a normal reading, non-decimal digits giving a reading above 999,
  // headers standing in as digits, a zero byte wrapping below '0', a reading
  // that puts the position below the setpoint, and more stray bytes.
  task automatic directed_words();
    send_byte(8'h00);
    send_byte(8'hff);
    send_reading(0, 123);
    send_byte(HDR_Y);
    repeat (3) send_byte(8'hff);
    send_byte(HDR_X);
    send_byte(HDR_X);
    send_byte(HDR_Y);
    send_byte(DIGIT_BASE);
    send_byte(HDR_Y);
    repeat (3) send_byte(8'h00);
    send_reading(0, 0);
    send_byte(DIGIT_BASE + 8'd5);
    send_byte(8'h7f);
    send_byte(8'h80);
  endtask

  // Mostly frames close to the setpoint, so that the settle counter gets to
  // snap, mixed with arbitrary readings, frames of raw digit bytes and stray
  // bytes between frames.
  task automatic random_traffic(input int count);
    int goal;
    int roll;
    int axis;
    int span;
    int lo;
    int hi;
    goal = sent_words + count;
    while (sent_words < goal) begin
      roll = $urandom_range(99);
      axis = $urandom_range(1);
      if (roll < 65) begin
        span = sb.window + 3;
        lo   = sb.setpoint[axis] - span;
        hi   = sb.setpoint[axis] + span;
        if (lo < 0) lo = 0;
        if (hi > DECIMAL_MAX) hi = DECIMAL_MAX;
        if (lo > hi) lo = hi;
        send_reading(axis, $urandom_range(hi, lo));
      end else if (roll < 78) begin
        send_reading(axis, $urandom_range(DECIMAL_MAX));
      end else if (roll < 88) begin
        send_byte(axis ? HDR_Y : HDR_X);
        repeat (3) send_byte(8'($urandom));
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  // Waits until every expected result has been taken, then waits out the drain
  // time in case the last word was a header or a digit still being absorbed.
  task automatic wait_for_results();
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = 8'h00;
    cfg_valid     = 1'b0;
    cfg_addr      = REG_X_SETPOINT;
    cfg_data      = '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    sent_words    = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      apply_phase(p);
      if (p == 0) directed_words();
      random_traffic(RANDOM_WORDS);
      @(negedge clk);
      in_tvalid <= 1'b0;
      wait_for_results();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
